>>> hw/rtl/event_priority_queue_top_macros.svh
// Assertion macros for the event priority queue.
// Used by event_priority_queue_top; needs i_clk and i_rst_n in scope.
`ifndef EVENT_PRIORITY_QUEUE_TOP_MACROS_SVH
`define EVENT_PRIORITY_QUEUE_TOP_MACROS_SVH

// implication checked at every clock edge outside reset
`define EPQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication with the consequent checked in the next cycle
`define EPQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/epq_pkg.sv
// Shared types, codes and the ordering function of the event priority queue.
// No dependencies.
package epq_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int ID_W         = 8;
    localparam int ID_SLOTS     = 256;
    localparam int DATA_W       = 32;
    localparam int CNT_W        = 9;
    localparam int STAT_W       = 3;

    localparam logic [1:0] CMD_INSERT  = 2'd0;
    localparam logic [1:0] CMD_DELETE  = 2'd1;
    localparam logic [1:0] CMD_PEEK    = 2'd2;
    localparam logic [1:0] CMD_EXTRACT = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 3'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd2;
    localparam logic [STAT_W-1:0] ST_ABSENT  = 3'd3;
    localparam logic [STAT_W-1:0] ST_PRESENT = 3'd4;

    typedef struct packed {
        logic [ID_W-1:0]          id;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] key;
    } t_entry;

    typedef struct packed {
        logic            ins;
        logic            del;
        logic [ID_W-1:0] del_id;
        t_entry          entry;
    } t_ctl;

    // a precedes b: lower key, then lower x; a full tie puts a (newer) first
    function automatic logic lex_le(input t_entry a, input t_entry b);
        logic r;
        if (a.key != b.key) begin
            r = (a.key < b.key);
        end else begin
            r = (a.x <= b.x);
        end
        return r;
    endfunction

endpackage

>>> hw/rtl/event_priority_queue_top.sv
// Event priority queue: a sorted chain of cells, minimum at the head.
// Depends on epq_pkg, epq_cell and event_priority_queue_top_macros.svh.
//
// A request is taken when start is high and busy is low; its result appears
// on the next cycle for one cycle, marked by o_done, and cannot be stalled.
// Peek only reads the head; insert adds the key, then shifts the chain once. Delete
// and extract keep busy high while the hole left by the removed entry walks
// cell by cell to the tail of the chain.
`include "event_priority_queue_top_macros.svh"
module event_priority_queue_top
    import epq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               i_command,
    input  logic [ID_W-1:0]          i_event_id,
    input  logic signed [DATA_W-1:0] i_site_x,
    input  logic signed [DATA_W-1:0] i_site_y,
    input  logic signed [DATA_W-1:0] i_key_offset,
    output logic                     o_done,
    output logic [STAT_W-1:0]        o_status,
    output logic [ID_W-1:0]          o_min_id,
    output logic signed [DATA_W-1:0] o_min_x,
    output logic signed [DATA_W-1:0] o_min_key,
    output logic                     o_queue_empty,
    output logic [CNT_W-1:0]         o_entry_count
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_INS  = 2'b10
    } t_state;

    t_state r_state, n_state;
    t_entry r_new;
    logic [ID_SLOTS-1:0] r_id_valid, n_id_valid;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [STAT_W-1:0]   n_status;
    logic                n_hit;

    t_entry w_entry [CAPACITY];
    logic [CAPACITY-1:0] w_valid;
    logic [CAPACITY-1:0] w_p;
    logic                w_hole;
    logic                w_accept;
    logic [DATA_W:0]     w_sum;
    logic signed [DATA_W-1:0] w_key;
    t_ctl                w_ctl;

    assign w_hole   = |(~w_valid[CAPACITY-2:0] & w_valid[CAPACITY-1:1]);
    assign busy     = (r_state != S_IDLE) || w_hole;
    assign w_accept = start && !busy;

    assign w_sum = {i_site_y[DATA_W-1], i_site_y} + {i_key_offset[DATA_W-1], i_key_offset};
    always_comb begin
        if (w_sum[DATA_W] != w_sum[DATA_W-1]) begin
            w_key = w_sum[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end else begin
            w_key = w_sum[DATA_W-1:0];
        end
    end

    always_comb begin
        n_state    = S_IDLE;
        n_id_valid = r_id_valid;
        n_count    = r_count;
        n_status   = ST_OK;
        n_hit      = 1'b0;
        w_ctl.ins    = (r_state == S_INS);
        w_ctl.del    = 1'b0;
        w_ctl.del_id = i_event_id;
        w_ctl.entry  = r_new;
        if (w_accept) begin
            case (i_command)
                CMD_INSERT: begin
                    if (r_id_valid[i_event_id]) begin
                        n_status = ST_PRESENT;
                    end else if (int'(r_count) >= CAPACITY) begin
                        n_status = ST_FULL;
                    end else begin
                        n_state                = S_INS;
                        n_id_valid[i_event_id] = 1'b1;
                        n_count                = r_count + 1'b1;
                    end
                end
                CMD_DELETE: begin
                    if (!r_id_valid[i_event_id]) begin
                        n_status = ST_ABSENT;
                    end else begin
                        w_ctl.del              = 1'b1;
                        n_id_valid[i_event_id] = 1'b0;
                        n_count                = r_count - 1'b1;
                    end
                end
                CMD_PEEK, CMD_EXTRACT: begin
                    if (r_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_hit = 1'b1;
                        if (i_command == CMD_EXTRACT) begin
                            w_ctl.del                    = 1'b1;
                            w_ctl.del_id                 = w_entry[0].id;
                            n_id_valid[w_entry[0].id]    = 1'b0;
                            n_count                      = r_count - 1'b1;
                        end
                    end
                end
                default: n_status = ST_OK;
            endcase
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_entry w_prev, w_next;
        logic   w_prev_valid, w_prev_p, w_next_valid;
        if (g == 0) begin : g_head
            assign w_prev       = w_entry[0];
            assign w_prev_valid = 1'b1;
            assign w_prev_p     = 1'b0;
        end else begin : g_body
            assign w_prev       = w_entry[g-1];
            assign w_prev_valid = w_valid[g-1];
            assign w_prev_p     = w_p[g-1];
        end
        if (g == CAPACITY - 1) begin : g_tail
            assign w_next       = w_entry[g];
            assign w_next_valid = 1'b0;
        end else begin : g_mid
            assign w_next       = w_entry[g+1];
            assign w_next_valid = w_valid[g+1];
        end
        epq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_prev       (w_prev),
            .i_prev_valid (w_prev_valid),
            .i_prev_p     (w_prev_p),
            .i_next       (w_next),
            .i_next_valid (w_next_valid),
            .o_entry      (w_entry[g]),
            .o_valid      (w_valid[g]),
            .o_p          (w_p[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_id_valid <= '0;
            r_count    <= '0;
            o_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_id_valid <= n_id_valid;
            r_count    <= n_count;
            o_done     <= w_accept;
        end
        if (w_accept) begin
            r_new.id      <= i_event_id;
            r_new.x       <= i_site_x;
            r_new.key     <= w_key;
            o_status      <= n_status;
            o_min_id      <= n_hit ? w_entry[0].id : '0;
            o_min_x       <= n_hit ? w_entry[0].x : '0;
            o_min_key     <= n_hit ? w_entry[0].key : '0;
            o_queue_empty <= (n_count == '0);
            o_entry_count <= n_count;
        end
    end

    `EPQ_ASSERT_NXT(a_done_follows, w_accept, o_done, "request without result")
    `EPQ_ASSERT_IMP(a_done_cause, o_done, $past(w_accept), "result without request")
    `EPQ_ASSERT_IMP(a_count_cells, r_state == S_IDLE, $countones(w_valid) == int'(r_count),
        "count differs from occupied cells")
    `EPQ_ASSERT_IMP(a_ins_no_hole, r_state == S_INS, !w_hole, "insert while hole open")

endmodule

>>> hw/rtl/epq_cell.sv
// One cell of the sorted entry chain: holds one entry, shifts on insert,
// closes a hole from its right neighbour. Depends on epq_pkg.
module epq_cell
    import epq_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_ctl   i_ctl,
    input  t_entry i_prev,
    input  logic   i_prev_valid,
    input  logic   i_prev_p,
    input  t_entry i_next,
    input  logic   i_next_valid,
    output t_entry o_entry,
    output logic   o_valid,
    output logic   o_p
);

    t_entry r_entry, n_entry;
    logic   r_valid, n_valid;

    assign o_p     = !r_valid || lex_le(i_ctl.entry, r_entry);
    assign o_entry = r_entry;
    assign o_valid = r_valid;

    always_comb begin
        n_entry = r_entry;
        n_valid = r_valid;
        if (i_ctl.ins) begin
            if (o_p && !i_prev_p) begin
                n_entry = i_ctl.entry;
                n_valid = 1'b1;
            end else if (o_p) begin
                n_entry = i_prev;
                n_valid = i_prev_valid;
            end
        end else if (i_ctl.del && r_valid && (r_entry.id == i_ctl.del_id)) begin
            n_valid = 1'b0;
        end else if (!r_valid && i_next_valid) begin
            n_entry = i_next;
            n_valid = 1'b1;
        end else if (r_valid && !i_prev_valid) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_entry <= n_entry;
    end

endmodule
